@@ rtl/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  typedef logic [7:0]  text_byte_t;
  typedef logic [15:0] code_unit_t;

  // Number of code units one byte can cause, and width of a count of them.
  localparam int MaxUnits   = 4;
  localparam int UnitCountW = $clog2(MaxUnits + 1);
  localparam int UnitIdxW   = $clog2(MaxUnits);

  localparam code_unit_t Replacement = 16'hFFFD;
  localparam code_unit_t HighSurr    = 16'hD800;
  localparam code_unit_t LowSurr     = 16'hDC00;
  localparam logic [20:0] SuppBase   = 21'h10000;

  localparam text_byte_t LeadMin     = 8'hC2;
  localparam text_byte_t LeadMax     = 8'hF4;
  localparam text_byte_t LeadThree   = 8'hE0;
  localparam text_byte_t LeadFour    = 8'hF0;
  localparam text_byte_t LeadSurr    = 8'hED;
  localparam text_byte_t ContA0      = 8'hA0;
  localparam text_byte_t Cont90      = 8'h90;
  localparam text_byte_t Cont8F      = 8'h8F;

endpackage

@@ rtl/u8u16_byte_if.sv @@
// ----------------------------------------------------------------------------
// u8u16_byte_if
// Valid/ready channel carrying one UTF-8 byte and its end-of-text flag.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
  import u8u16_pkg::*;

  logic       valid;
  logic       ready;
  text_byte_t text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

@@ rtl/u8u16_unit_if.sv @@
// ----------------------------------------------------------------------------
// u8u16_unit_if
// Valid/ready channel carrying one UTF-16 code unit with its markers.
// ----------------------------------------------------------------------------
interface u8u16_unit_if;
  import u8u16_pkg::*;

  logic       valid;
  logic       ready;
  code_unit_t code_unit;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output code_unit, output run_last, output text_end,
                  input ready);
  modport sink   (input valid, input code_unit, input run_last, input text_end,
                  output ready);
endinterface

@@ rtl/utf8_to_utf16_transcoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streaming UTF-8 decoder that emits UTF-16 code units, with U+FFFD
// replacement of every malformed, overlong, surrogate, out-of-range or
// truncated sequence.
// ----------------------------------------------------------------------------
// Bytes arrive on the "bytes" channel, one per transaction, with final_byte
// marking the end of the text; code units leave on the "units" channel.
// Each byte is decoded in the cycle it is accepted, against the held lead
// and continuation bytes, and the zero to four code units it causes are
// loaded into a result buffer that drains one unit per cycle while the
// receiver is ready. A byte can be accepted in every cycle while the buffer
// is empty or is handing over its last unit, so a byte that gives several
// units holds off the next byte until its last unit is sent. A four-byte
// sequence gives a surrogate pair on its last byte. run_last marks the last
// unit caused by a byte, text_end the last unit of the text. A final byte
// that gives no unit of its own cannot occur: a flush always produces at
// least one unit.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  u8u16_byte_if.sink   bytes,
  u8u16_unit_if.source units
);

  // Decoder state: held lead, held continuations, number of bytes held.
  text_byte_t held_lead;
  text_byte_t held_cont0;
  text_byte_t held_cont1;
  logic [1:0] held_count;

  // Result buffer: the units of one byte, how many, and the next to send.
  code_unit_t            buf_units [MaxUnits];
  logic [UnitCountW-1:0] buf_count;
  logic [UnitIdxW-1:0]   buf_idx;
  logic                  buf_fin;

  logic buf_last;
  logic accept;

  // Decode signals.
  text_byte_t            b;
  logic                  fin;
  logic [2:0]            need;
  logic                  ok;
  logic                  complete;
  logic [20:0]           cp;
  logic [19:0]           supp;
  logic                  lt_hold;
  logic                  lt_emit;
  code_unit_t            lt_unit;
  code_unit_t            units_next [MaxUnits];
  logic [UnitCountW-1:0] count_next;
  logic                  lead_load;
  logic                  cont_store;
  logic [1:0]            held_count_next;

  // Output side: show the current unit of the buffer.
  assign buf_last        = ({1'b0, buf_idx} + UnitCountW'(1)) == buf_count;
  assign units.valid     = buf_count != '0;
  assign units.code_unit = buf_units[buf_idx];
  assign units.run_last  = buf_last;
  assign units.text_end  = buf_last && buf_fin;

  // Take a new byte when the buffer is empty or its last unit leaves now.
  assign bytes.ready = (buf_count == '0) || (buf_last && units.ready);
  assign accept      = bytes.valid && bytes.ready;

  assign b   = bytes.text_byte;
  assign fin = bytes.final_byte;

  always_comb begin
    // Treatment of the byte as a new lead.
    lt_hold = 1'b0;
    lt_emit = 1'b1;
    lt_unit = Replacement;
    if (!b[7]) begin
      lt_unit = {8'h00, b};
    end else if (b >= LeadMin && b <= LeadMax && !fin) begin
      lt_hold = 1'b1;
      lt_emit = 1'b0;
    end

    // Sequence length of the held lead.
    if (held_lead >= LeadFour) begin
      need = 3'd4;
    end else if (held_lead >= LeadThree) begin
      need = 3'd3;
    end else begin
      need = 3'd2;
    end

    // Continuation check, with the range rules on the second byte.
    ok = b[7:6] == 2'b10;
    if (held_count == 2'd1) begin
      if (held_lead == LeadThree && b <  ContA0) ok = 1'b0;
      if (held_lead == LeadSurr  && b >= ContA0) ok = 1'b0;
      if (held_lead == LeadFour  && b <  Cont90) ok = 1'b0;
      if (held_lead == LeadMax   && b >  Cont8F) ok = 1'b0;
    end
    complete = ({1'b0, held_count} + 3'd1) >= need;

    // Assemble the code point.
    unique case (need)
      3'd2:    cp = {10'd0, held_lead[4:0], b[5:0]};
      3'd3:    cp = {5'd0, held_lead[3:0], held_cont0[5:0], b[5:0]};
      default: cp = {held_lead[2:0], held_cont0[5:0], held_cont1[5:0], b[5:0]};
    endcase
    supp = 20'(cp - SuppBase);

    // Fill the result list; unused slots hold the replacement character.
    for (int k = 0; k < MaxUnits; k++) begin
      units_next[k] = Replacement;
    end
    count_next      = '0;
    lead_load       = 1'b0;
    cont_store      = 1'b0;
    held_count_next = held_count;

    if (held_count == 2'd0) begin
      units_next[0] = lt_unit;
      count_next    = UnitCountW'(lt_emit);
      lead_load     = lt_hold;
      if (lt_hold) held_count_next = 2'd1;
    end else if (ok && complete) begin
      held_count_next = 2'd0;
      if (cp[20:16] == 5'd0) begin
        units_next[0] = cp[15:0];
        count_next    = UnitCountW'(1);
      end else begin
        units_next[0] = HighSurr | {6'd0, supp[19:10]};
        units_next[1] = LowSurr  | {6'd0, supp[9:0]};
        count_next    = UnitCountW'(2);
      end
    end else if (ok) begin
      if (fin) begin
        // Flush: one replacement for the lead and for every continuation.
        count_next      = UnitCountW'(held_count) + UnitCountW'(1);
        held_count_next = 2'd0;
      end else begin
        cont_store      = 1'b1;
        held_count_next = held_count + 2'd1;
      end
    end else begin
      // Reject the held bytes, then take this byte as a new lead.
      units_next[held_count] = lt_unit;
      count_next      = UnitCountW'(held_count) + UnitCountW'(lt_emit);
      lead_load       = lt_hold;
      held_count_next = lt_hold ? 2'd1 : 2'd0;
    end

    if (fin) held_count_next = 2'd0;
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead  <= '0;
      held_count <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
      if (lead_load) held_lead <= b;
    end
  end

  // Held continuations: written before they are read.
  always_ff @(posedge clk) begin
    if (accept && cont_store) begin
      if (held_count == 2'd1) begin
        held_cont0 <= b;
      end else begin
        held_cont1 <= b;
      end
    end
  end

  // Result buffer control: load on accept, advance on each sent unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= '0;
      buf_idx   <= '0;
      buf_fin   <= 1'b0;
    end else if (accept) begin
      buf_count <= count_next;
      buf_idx   <= '0;
      buf_fin   <= fin;
    end else if (units.valid && units.ready) begin
      if (buf_last) begin
        buf_count <= '0;
        buf_idx   <= '0;
      end else begin
        buf_idx <= buf_idx + UnitIdxW'(1);
      end
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MaxUnits; k++) begin
        buf_units[k] <= units_next[k];
      end
    end
  end

endmodule

@@ sim/tb_utf8_to_utf16_transcoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder
// Self-checking bench for the UTF-8 to UTF-16 transcoder. A short stimulus
// table covers ASCII, stray and illegal bytes, every range rejection, the
// largest code point and the flush cases. About 330 random bytes follow,
// mostly well-formed characters of every length, mixed with truncated
// sequences, range violations and noise. Each code unit the block returns is
// compared with the units typed into its table row or with the bench's behavioral decoder.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder;
  import u8u16_pkg::*;

  // One byte of text. n_typed >= 0 means the expected units are typed into
  // the row itself (first unit in the top 16 bits of typed); -1 means the
  // behavioral decoder supplies them.
  typedef struct packed {
    text_byte_t  b;
    logic        fin;
    int          n_typed;
    logic [63:0] typed;
  } byte_item_t;

  typedef struct packed {
    code_unit_t unit;
    logic       run_last;
    logic       text_end;
  } unit_exp_t;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 20;
  localparam int RandomBytes   = 333;

  logic clk;
  logic rst;

  u8u16_byte_if byte_ch ();
  u8u16_unit_if unit_ch ();

  utf8_to_utf16_transcoder dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_ch),
    .units (unit_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Stimulus table. Rows whose result is obvious carry it; rows that only
  // hold a byte, or complete an ordinary character, go to the decoder.
  // --------------------------------------------------------------------------
  byte_item_t directed_rows [27] = '{
    // plain ASCII extremes right after reset
    '{8'h00, 1'b0,  1, {16'h0000, 48'h0}},
    '{8'h7F, 1'b0,  1, {16'h007F, 48'h0}},
    // stray continuation and illegal leads
    '{8'h80, 1'b0,  1, {Replacement, 48'h0}},
    '{8'hC1, 1'b0,  1, {Replacement, 48'h0}},
    '{8'hF5, 1'b0,  1, {Replacement, 48'h0}},
    // smallest two-byte character
    '{8'hC2, 1'b0, -1, 64'h0},
    '{8'h80, 1'b0, -1, 64'h0},
    // overlong three-byte form: lead rejected, then the byte itself is stray
    '{8'hE0, 1'b0, -1, 64'h0},
    '{8'h9F, 1'b0,  2, {Replacement, Replacement, 32'h0}},
    // surrogate range
    '{8'hED, 1'b0, -1, 64'h0},
    '{8'hA0, 1'b0,  2, {Replacement, Replacement, 32'h0}},
    // beyond 10FFFF
    '{8'hF4, 1'b0, -1, 64'h0},
    '{8'h90, 1'b0,  2, {Replacement, Replacement, 32'h0}},
    // overlong four-byte form
    '{8'hF0, 1'b0, -1, 64'h0},
    '{8'h8F, 1'b0,  2, {Replacement, Replacement, 32'h0}},
    // largest code point, 10FFFF, as a surrogate pair
    '{8'hF4, 1'b0, -1, 64'h0},
    '{8'h8F, 1'b0, -1, 64'h0},
    '{8'hBF, 1'b0, -1, 64'h0},
    '{8'hBF, 1'b0,  2, {16'hDBFF, 16'hDFFF, 32'h0}},
    // full hold then an illegal byte: four replacements from one byte
    '{8'hF1, 1'b0, -1, 64'h0},
    '{8'h80, 1'b0, -1, 64'h0},
    '{8'h80, 1'b0, -1, 64'h0},
    '{8'hF5, 1'b0,  4, {Replacement, Replacement, Replacement, Replacement}},
    // truncated by the final byte: lead plus the arriving continuation
    '{8'hE2, 1'b0, -1, 64'h0},
    '{8'h82, 1'b1,  2, {Replacement, Replacement, 32'h0}},
    // a valid lead as the final byte, then a stray final byte
    '{8'hC3, 1'b1,  1, {Replacement, 48'h0}},
    '{8'hFF, 1'b1,  1, {Replacement, 48'h0}}
  };

  byte_item_t text_q [$];
  unit_exp_t  pending_units [$];
  code_unit_t decoded [$];

  // Decoder state, mirrors what the block holds between bytes.
  text_byte_t held_lead;
  text_byte_t held_cont [2];
  logic [1:0] held_n;

  int bytes_done;
  int offered_idx;
  int units_checked;
  int pairs_seen;
  int texts_ended;
  int mismatches;
  int quiet_cycles;
  int phase;
  int send_idle_pct;
  int recv_idle_pct;

  task automatic report_mismatch(string msg);
    $display("MISMATCH (unit %0d): %s", units_checked, msg);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Behavioral decoder
  // --------------------------------------------------------------------------

  // Append one code unit to the units of the current byte.
  function automatic void add_unit(code_unit_t u);
    decoded.insert(decoded.size(), u);
  endfunction

  // Handle a byte as the start of a new character.
  function automatic void start_char(text_byte_t b, logic fin);
    if (b < 8'h80) begin
      add_unit({8'h00, b});
    end else if (b >= LeadMin && b <= LeadMax && !fin) begin
      held_lead = b;
      held_n    = 2'd1;
    end else begin
      add_unit(Replacement);
    end
  endfunction

  // Decode one byte against the held bytes; leaves the units in decoded.
  function automatic void decode_byte(text_byte_t b, logic fin);
    int          need;
    logic        ok;
    logic [20:0] cp;
    logic [19:0] off;
    decoded.delete();
    if (held_n == 2'd0) begin
      start_char(b, fin);
    end else begin
      need = (held_lead >= LeadFour) ? 4 : (held_lead >= LeadThree) ? 3 : 2;
      ok   = (b[7:6] == 2'b10);
      // range rules only apply to the byte right after the lead
      if (held_n == 2'd1) begin
        if (held_lead == LeadThree && b < ContA0) ok = 1'b0;
        if (held_lead == LeadSurr && b >= ContA0) ok = 1'b0;
        if (held_lead == LeadFour && b < Cont90) ok = 1'b0;
        if (held_lead == LeadMax && b > Cont8F) ok = 1'b0;
      end
      if (ok && held_n + 1 >= need) begin
        case (need)
          2:       cp = {10'b0, held_lead[4:0], b[5:0]};
          3:       cp = {5'b0, held_lead[3:0], held_cont[0][5:0], b[5:0]};
          default: cp = {held_lead[2:0], held_cont[0][5:0], held_cont[1][5:0], b[5:0]};
        endcase
        held_n = 2'd0;
        if (cp <= 21'h00FFFF) begin
          add_unit(cp[15:0]);
        end else begin
          off = 20'(cp - SuppBase);
          add_unit(HighSurr + off[19:10]);
          add_unit(LowSurr + off[9:0]);
        end
      end else if (ok) begin
        if (fin) begin
          repeat (held_n + 1) add_unit(Replacement);
        end else begin
          held_cont[held_n - 1] = b;
          held_n++;
        end
      end else begin
        // drop the held lead and each held continuation, then restart
        repeat (held_n) add_unit(Replacement);
        held_n = 2'd0;
        start_char(b, fin);
      end
    end
    if (fin) held_n = 2'd0;
  endfunction

  // --------------------------------------------------------------------------
  // Random text
  // --------------------------------------------------------------------------

  function automatic void push_text_byte(text_byte_t b);
    byte_item_t it;
    it = '{b: b, fin: 1'b0, n_typed: -1, typed: 64'h0};
    text_q.insert(text_q.size(), it);
  endfunction

  // Legal byte after a lead, or one that breaks the lead's range rule.
  function automatic text_byte_t second_byte(text_byte_t lead, logic bad);
    case (lead)
      LeadThree: return bad ? 8'($urandom_range(8'h80, 8'h9F))
                            : 8'($urandom_range(8'hA0, 8'hBF));
      LeadSurr:  return bad ? 8'($urandom_range(8'hA0, 8'hBF))
                            : 8'($urandom_range(8'h80, 8'h9F));
      LeadFour:  return bad ? 8'($urandom_range(8'h80, 8'h8F))
                            : 8'($urandom_range(8'h90, 8'hBF));
      LeadMax:   return bad ? 8'($urandom_range(8'h90, 8'hBF))
                            : 8'($urandom_range(8'h80, 8'h8F));
      default:   return bad ? 8'($urandom_range(0, 127))
                            : 8'($urandom_range(8'h80, 8'hBF));
    endcase
  endfunction

  task automatic build_random_text(int target);
    int         pick;
    int         len;
    int         ncont;
    text_byte_t lead;
    while (text_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        push_text_byte(8'($urandom_range(0, 127)));
      end else if (pick < 90) begin
        // 30..81 complete characters, 82..89 truncated or broken ones
        len = (pick < 50) ? 2 : (pick < 68) ? 3 : 4;
        if (pick >= 82) len = $urandom_range(2, 4);
        case (len)
          2: lead = 8'($urandom_range(LeadMin, 8'hDF));
          3: begin
            if ($urandom_range(2) == 0) lead = $urandom_range(1) ? LeadThree : LeadSurr;
            else lead = 8'($urandom_range(LeadThree, 8'hEF));
          end
          default: lead = 8'($urandom_range(LeadFour, LeadMax));
        endcase
        push_text_byte(lead);
        if (pick >= 82 && pick < 86) begin
          push_text_byte(second_byte(lead, 1'b1));
        end else begin
          ncont = (pick < 82) ? len - 1 : $urandom_range(0, len - 2);
          for (int i = 0; i < ncont; i++) begin
            push_text_byte((i == 0) ? second_byte(lead, 1'b0)
                                    : 8'($urandom_range(8'h80, 8'hBF)));
          end
        end
      end else begin
        push_text_byte(8'($urandom_range(0, 255)));
      end
      // end a text now and then, often in the middle of a sequence
      if ($urandom_range(24) == 0) text_q[text_q.size() - 1].fin = 1'b1;
    end
    text_q[text_q.size() - 1].fin = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Driver: change inputs on the falling edge. A byte on offer stays on
  // offer until its transaction completes. Idle rates shift over three
  // phases: receiver slow, then sender slow, then both at full rate.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst !== 1'b0) begin
      byte_ch.valid <= 1'b0;
      unit_ch.ready <= 1'b0;
    end else begin
      phase         = (bytes_done * 3) / text_q.size();
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 25 : 0;
      unit_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      // hold the current byte while it is still waiting to be taken
      if (!(byte_ch.valid && bytes_done == offered_idx)) begin
        if (bytes_done >= text_q.size() || $urandom_range(99) < send_idle_pct) begin
          byte_ch.valid <= 1'b0;
        end else begin
          byte_ch.valid      <= 1'b1;
          byte_ch.text_byte  <= text_q[bytes_done].b;
          byte_ch.final_byte <= text_q[bytes_done].fin;
          offered_idx = bytes_done;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: on the rising edge, turn each accepted byte into expected code
  // units, then compare each accepted code unit with the oldest expectation.
  // The byte side is handled first so that even a same-cycle result lines up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_item_t it;
    unit_exp_t  want;
    int         n;
    if (!rst) begin
      quiet_cycles++;
      if (byte_ch.valid && byte_ch.ready) begin
        it = text_q[bytes_done];
        // always advance the decoder so its state tracks the block
        decode_byte(byte_ch.text_byte, byte_ch.final_byte);
        if (it.n_typed >= 0) begin
          decoded.delete();
          for (int k = 0; k < it.n_typed; k++) add_unit(it.typed[63 - 16 * k -: 16]);
        end
        n = decoded.size();
        for (int k = 0; k < n; k++) begin
          want.unit     = decoded[k];
          want.run_last = (k == n - 1);
          want.text_end = (k == n - 1) && byte_ch.final_byte;
          pending_units.insert(pending_units.size(), want);
        end
        bytes_done++;
        quiet_cycles = 0;
      end
      if (unit_ch.valid && unit_ch.ready) begin
        if (pending_units.size() == 0) begin
          report_mismatch($sformatf("unexpected code unit %h", unit_ch.code_unit));
        end else begin
          want = pending_units.pop_front();
          if (unit_ch.code_unit !== want.unit)
            report_mismatch($sformatf("code_unit %h, want %h", unit_ch.code_unit, want.unit));
          if (unit_ch.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b", unit_ch.run_last, want.run_last));
          if (unit_ch.text_end !== want.text_end)
            report_mismatch($sformatf("text_end %b, want %b", unit_ch.text_end, want.text_end));
          if (want.unit >= HighSurr && want.unit < LowSurr) pairs_seen++;
          if (want.text_end) texts_ended++;
        end
        units_checked++;
        quiet_cycles = 0;
      end
      // a stalled handshake on both sides for this long means a hang
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles, %0d of %0d bytes taken",
                 WatchdogLimit, bytes_done, text_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build the text, reset, let the driver run, then drain.
  // --------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    byte_ch.valid      = 1'b0;
    byte_ch.text_byte  = '0;
    byte_ch.final_byte = 1'b0;
    unit_ch.ready      = 1'b0;
    bytes_done         = 0;
    offered_idx        = -1;
    units_checked      = 0;
    pairs_seen         = 0;
    texts_ended        = 0;
    mismatches         = 0;
    quiet_cycles       = 0;
    held_lead          = '0;
    held_n             = 2'd0;

    foreach (directed_rows[i]) text_q.insert(text_q.size(), directed_rows[i]);
    build_random_text(text_q.size() + RandomBytes);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // wait for every byte to be taken and every expected unit to arrive
    while (bytes_done < text_q.size() || pending_units.size() != 0) @(negedge clk);
    // keep watching a little longer for stray extra units
    repeat (DrainCycles) @(negedge clk);

    $display("Sent %0d UTF-8 bytes (%0d from the table), checked %0d code units.",
             text_q.size(), $size(directed_rows), units_checked);
    $display("Saw %0d surrogate pairs and %0d text ends; %0d mismatches.",
             pairs_seen, texts_ended, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
